// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// ===== hdl/psd_pkg.sv =====
// Shared constants, arctangent table and width helpers for the principal stress pipeline.
package psd_pkg;

  localparam int ACC_W    = 34;
  localparam int ANG_W    = 17;
  localparam int ANG_FRAC = 16;
  localparam int ATAN_N   = 32;

  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  localparam logic signed [ACC_W-1:0] ACC_PI   = ACC_W'(64'sd2147483648);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] ANG_POS  = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] ANG_NEG  = ACC_W'(-32768);

  localparam logic signed [ANG_W-1:0] ANG_OUT_MAX = ANG_W'(32768);
  localparam logic signed [ANG_W-1:0] ANG_OUT_MIN = ANG_W'(-32768);

  localparam logic [30:0] ATAN_TAB [ATAN_N] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
    31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
    31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
    31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163,
    31'd81, 31'd41, 31'd20, 31'd10, 31'd5, 31'd3, 31'd1, 31'd1, 31'd0
  };

  function automatic int guard_bits(input int dw);
    return (dw > 42) ? 58 - dw : 16;
  endfunction

  function automatic int work_width(input int dw);
    return dw + guard_bits(dw) + 4;
  endfunction

endpackage

// ===== hdl/principal_stress_2d_top.sv =====
// Top level of the pipelined Mohr circle principal stress unit.
// Accepts one plane stress transaction per cycle while the pipeline is not stalled and returns one
// result per transaction in order, through one front stage, one register stage per CORDIC
// iteration and three back-end stages for gain multiply, correction add and rounding. Each
// stage holds under back-pressure and collapses bubbles, so input is taken while any stage
// ahead has room, including while a finished result waits at the output.
`include "assert_macros.svh"

module principal_stress_2d_top import psd_pkg::*; #(
  parameter int DATA_WIDTH   = 24,
  parameter int CORDIC_STEPS = 18
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // normal_x, normal_y, shear_xy (lowest bits first), zero padded
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // major_principal, minor_principal, max_shear, principal_angle (lowest first), zero padded
  output logic [((3*DATA_WIDTH+21+7)/8)*8-1:0]   m_axis_tdata
);

  localparam int W     = work_width(DATA_WIDTH);
  localparam int OUT_W = ((3*DATA_WIDTH+21+7)/8)*8;
  localparam int PK_W  = 3*DATA_WIDTH + 21;

  logic signed [W-1:0]     x_s      [CORDIC_STEPS+1];
  logic signed [W-1:0]     y_s      [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] acc_s    [CORDIC_STEPS+1];
  logic signed [W-1:0]     centre_s [CORDIC_STEPS+1];
  logic                    zero_s   [CORDIC_STEPS+1];
  logic                    valid_s  [CORDIC_STEPS+1];
  logic                    ready_s  [CORDIC_STEPS+1];

  logic signed [DATA_WIDTH+1:0] major, minor;
  logic [DATA_WIDTH-1:0]        shear;
  logic signed [ANG_W-1:0]      angle;

  psd_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .normal_x_i ($signed(s_axis_tdata[DATA_WIDTH-1:0])),
    .normal_y_i ($signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
    .shear_xy_i ($signed(s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH])),
    .valid_o    (valid_s[0]),
    .ready_i    (ready_s[0]),
    .x_o        (x_s[0]),
    .y_o        (y_s[0]),
    .acc_o      (acc_s[0]),
    .centre_o   (centre_s[0]),
    .zero_o     (zero_s[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    psd_cordic_stage #(
      .DATA_WIDTH(DATA_WIDTH),
      .STEP      (i)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_s[i]),
      .ready_o  (ready_s[i]),
      .x_i      (x_s[i]),
      .y_i      (y_s[i]),
      .acc_i    (acc_s[i]),
      .centre_i (centre_s[i]),
      .zero_i   (zero_s[i]),
      .valid_o  (valid_s[i+1]),
      .ready_i  (ready_s[i+1]),
      .x_o      (x_s[i+1]),
      .y_o      (y_s[i+1]),
      .acc_o    (acc_s[i+1]),
      .centre_o (centre_s[i+1]),
      .zero_o   (zero_s[i+1])
    );
  end

  psd_post #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_post (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (valid_s[CORDIC_STEPS]),
    .ready_o           (ready_s[CORDIC_STEPS]),
    .x_i               (x_s[CORDIC_STEPS]),
    .acc_i             (acc_s[CORDIC_STEPS]),
    .centre_i          (centre_s[CORDIC_STEPS]),
    .zero_i            (zero_s[CORDIC_STEPS]),
    .valid_o           (m_axis_tvalid),
    .ready_i           (m_axis_tready),
    .major_principal_o (major),
    .minor_principal_o (minor),
    .max_shear_o       (shear),
    .principal_angle_o (angle)
  );

  assign m_axis_tdata = OUT_W'(PK_W'({angle, shear, minor, major}));

  `ASSERT_IMPL(a_full_when_blocked, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input blocked without output stall")
  `ASSERT_IMPL(a_angle_range, clk_i, rst_ni, m_axis_tvalid, (angle <= ANG_OUT_MAX) && (angle >= ANG_OUT_MIN), "principal angle out of range")
  `ASSERT_IMPL(a_major_ge_minor, clk_i, rst_ni, m_axis_tvalid, major >= minor, "major principal below minor principal")

endmodule

// ===== hdl/psd_prep.sv =====
// Front stage: difference, centre, pre-rotation into the right half plane and zero detect.
module psd_prep import psd_pkg::*; #(
  parameter int DATA_WIDTH = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [DATA_WIDTH-1:0]      normal_x_i,
  input  logic signed [DATA_WIDTH-1:0]      normal_y_i,
  input  logic signed [DATA_WIDTH-1:0]      shear_xy_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [work_width(DATA_WIDTH)-1:0] x_o,
  output logic signed [work_width(DATA_WIDTH)-1:0] y_o,
  output logic signed [ACC_W-1:0]           acc_o,
  output logic signed [work_width(DATA_WIDTH)-1:0] centre_o,
  output logic                              zero_o
);

  localparam int G  = guard_bits(DATA_WIDTH);
  localparam int W  = work_width(DATA_WIDTH);
  localparam int NW = DATA_WIDTH + 2;

  logic signed [NW-1:0] diff, ndiff, sum, twice, ntwice, x_sel, y_sel;
  logic                 neg;
  logic signed [W-1:0]  x_d, y_d, centre_d;
  logic signed [ACC_W-1:0] acc_d;
  logic                 zero_d;

  logic                 valid_q;
  logic                 en;
  logic signed [W-1:0]  x_q, y_q, centre_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                 zero_q;

  always_comb begin
    diff     = NW'(normal_x_i) - NW'(normal_y_i);
    ndiff    = NW'(normal_y_i) - NW'(normal_x_i);
    sum      = NW'(normal_x_i) + NW'(normal_y_i);
    twice    = NW'(shear_xy_i) <<< 1;
    ntwice   = -(NW'(shear_xy_i) <<< 1);
    neg      = diff[NW-1];
    x_sel    = neg ? ndiff : diff;
    y_sel    = neg ? ntwice : twice;
    x_d      = W'(x_sel) <<< G;
    y_d      = W'(y_sel) <<< G;
    centre_d = W'(sum) <<< G;
    zero_d   = (diff == '0) && (shear_xy_i == '0);
    if (!neg) begin
      acc_d = '0;
    end else if (!twice[NW-1]) begin
      acc_d = ACC_PI;
    end else begin
      acc_d = -ACC_PI;
    end
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q      <= x_d;
      y_q      <= y_d;
      acc_q    <= acc_d;
      centre_q <= centre_d;
      zero_q   <= zero_d;
    end
  end

  assign valid_o  = valid_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign acc_o    = acc_q;
  assign centre_o = centre_q;
  assign zero_o   = zero_q;

endmodule

// ===== hdl/psd_cordic_stage.sv =====
// One registered CORDIC vectoring iteration.
module psd_cordic_stage import psd_pkg::*; #(
  parameter int DATA_WIDTH = 24,
  parameter int STEP       = 0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic signed [work_width(DATA_WIDTH)-1:0] x_i,
  input  logic signed [work_width(DATA_WIDTH)-1:0] y_i,
  input  logic signed [ACC_W-1:0]                  acc_i,
  input  logic signed [work_width(DATA_WIDTH)-1:0] centre_i,
  input  logic                                     zero_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic signed [work_width(DATA_WIDTH)-1:0] x_o,
  output logic signed [work_width(DATA_WIDTH)-1:0] y_o,
  output logic signed [ACC_W-1:0]                  acc_o,
  output logic signed [work_width(DATA_WIDTH)-1:0] centre_o,
  output logic                                     zero_o
);

  localparam int W = work_width(DATA_WIDTH);
  localparam logic signed [ACC_W-1:0] STEP_ANG = $signed(ACC_W'(ATAN_TAB[STEP]));

  logic signed [W-1:0]     dx, dy, x_d, y_d;
  logic signed [ACC_W-1:0] acc_d;
  logic                    valid_q;
  logic                    en;
  logic signed [W-1:0]     x_q, y_q, centre_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    zero_q;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!y_i[W-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      acc_d = acc_i + STEP_ANG;
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      acc_d = acc_i - STEP_ANG;
    end
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q      <= x_d;
      y_q      <= y_d;
      acc_q    <= acc_d;
      centre_q <= centre_i;
      zero_q   <= zero_i;
    end
  end

  assign valid_o  = valid_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign acc_o    = acc_q;
  assign centre_o = centre_q;
  assign zero_o   = zero_q;

endmodule

// ===== hdl/psd_post.sv =====
// Back end: gain correction multiply, angle rounding and clamp, final stress rounding.
module psd_post import psd_pkg::*; #(
  parameter int DATA_WIDTH = 24
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic signed [work_width(DATA_WIDTH)-1:0] x_i,
  input  logic signed [ACC_W-1:0]                  acc_i,
  input  logic signed [work_width(DATA_WIDTH)-1:0] centre_i,
  input  logic                                     zero_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic signed [DATA_WIDTH+1:0]             major_principal_o,
  output logic signed [DATA_WIDTH+1:0]             minor_principal_o,
  output logic        [DATA_WIDTH-1:0]             max_shear_o,
  output logic signed [ANG_W-1:0]                  principal_angle_o
);

  localparam int G = guard_bits(DATA_WIDTH);
  localparam int W = work_width(DATA_WIDTH);
  localparam logic signed [W:0] RND_HALF = {{(W-G){1'b0}}, 1'b1, {G{1'b0}}};

  logic [63:0]             mag;
  logic signed [ACC_W-1:0] acc_eff, acc_rnd, ang_sh;
  logic signed [ANG_W-1:0] ang_d;
  logic [63:0]             r_full;
  logic signed [W:0]       hi_sum, lo_sum, r_sum;

  logic                    v1_q, v2_q, v3_q;
  logic                    en1, en2, en3;
  logic [63:0]             p_hi_q, p_lo_q;
  logic signed [W-1:0]     centre1_q, centre2_q, r_q;
  logic signed [ANG_W-1:0] ang1_q, ang2_q, ang3_q;
  logic signed [DATA_WIDTH+1:0] major_q, minor_q;
  logic [DATA_WIDTH-1:0]   shear_q;

  always_comb begin
    mag     = 64'($unsigned(x_i));
    acc_eff = zero_i ? '0 : acc_i;
    acc_rnd = acc_eff + ACC_HALF;
    ang_sh  = acc_rnd >>> ANG_FRAC;
    if (ang_sh > ANG_POS) begin
      ang_d = ANG_W'(ANG_POS);
    end else if (ang_sh < ANG_NEG) begin
      ang_d = ANG_W'(ANG_NEG);
    end else begin
      ang_d = ANG_W'(ang_sh);
    end
  end

  assign r_full = p_hi_q + {32'd0, p_lo_q[63:32]};

  always_comb begin
    hi_sum = (W+1)'(centre2_q) + (W+1)'(r_q) + RND_HALF;
    lo_sum = (W+1)'(centre2_q) - (W+1)'(r_q) + RND_HALF;
    r_sum  = (W+1)'(r_q) + RND_HALF;
  end

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p_hi_q    <= 64'(mag[63:32]) * 64'(INV_GAIN);
      p_lo_q    <= 64'(mag[31:0]) * 64'(INV_GAIN);
      centre1_q <= centre_i;
      ang1_q    <= ang_d;
    end
    if (en2) begin
      r_q       <= $signed(r_full[W-1:0]);
      centre2_q <= centre1_q;
      ang2_q    <= ang1_q;
    end
    if (en3) begin
      major_q <= (DATA_WIDTH+2)'(hi_sum >>> (G + 1));
      minor_q <= (DATA_WIDTH+2)'(lo_sum >>> (G + 1));
      shear_q <= DATA_WIDTH'(r_sum >>> (G + 1));
      ang3_q  <= ang2_q;
    end
  end

  assign valid_o           = v3_q;
  assign major_principal_o = major_q;
  assign minor_principal_o = minor_q;
  assign max_shear_o       = shear_q;
  assign principal_angle_o = ang3_q;

endmodule
